FILE: rtl/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

   // input item kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   // result item kinds
   localparam logic RESULT_DATA   = 1'b0;
   localparam logic RESULT_STATUS = 1'b1;

   // record status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_SHORT    = 3'd1;
   localparam logic [2:0] STATUS_NO_COLON = 3'd2;
   localparam logic [2:0] STATUS_LENGTH   = 3'd3;
   localparam logic [2:0] STATUS_EOF_CNT  = 3'd4;
   localparam logic [2:0] STATUS_TYPE     = 3'd5;
   localparam logic [2:0] STATUS_CHECKSUM = 3'd6;

   // record types
   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_EOF  = 8'h01;

   // line format constants
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] POS_LIMIT = 8'hFF;
   localparam logic [7:0] MIN_LEN = 8'd11;

   // one result transaction
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  data_byte;
      logic [5:0]  byte_index;
      logic [15:0] load_address;
      logic [7:0]  byte_count;
      logic [7:0]  record_type;
      logic [2:0]  status;
   } rsp_type;

   // digit mapping used by the file format, no validity check
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_UPPER_A && !c[7]) begin
         v = c - CHAR_UPPER_A + 8'd10;
      end else begin
         v = c - CHAR_ZERO;
      end
      return v;
   endfunction

   function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] h;
      h = digit_value(hi);
      return {h[3:0], 4'b0000} + digit_value(lo);
   endfunction

endpackage

FILE: rtl/intel_hex_record_parser_core.sv
`timescale 1ns / 1ps

// Intel HEX record parser core
//
// Input channel (req_): one transaction per line character (req_kind = 0,
// req_character holds the ASCII code) and one end-of-line transaction
// (req_kind = 1) per line. Result channel (rsp_): one transaction for each
// decoded data byte of a data record, as soon as its digit pair completes,
// and one status transaction at every end of line.
// The accepting edge loads the input register; the decoded result then goes
// to the output register, or to the skid register while the receiver stalls.
// One item is taken per cycle while req_stall is low, whether or not the item
// causes a result; the line decoder updates its state once for each item.
// When the receiver stalls, one further result parks in a skid register;
// after that, req_stall rises and the input register holds until the skid
// entry has moved on to the output. A stalled result holds its payload.
// Reset (synchronous, active high) clears the line state and empties the
// input, output and skid registers; the next character starts a new line.

module intel_hex_record_parser_core #(
   parameter int MAX_DATA = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_byte_index,
   output logic [15:0] rsp_load_address,
   output logic [7:0]  rsp_byte_count,
   output logic [7:0]  rsp_record_type,
   output logic [2:0]  rsp_status
);

   localparam logic [7:0] MaxData = MAX_DATA[7:0];

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff, in_kind_in;
   logic [7:0] in_char_ff, in_char_in;

   // line state
   logic [7:0]  char_position_ff, char_position_in;
   logic        line_overflow_ff, line_overflow_in;
   logic [7:0]  upper_digit_ff, upper_digit_in;
   logic [7:0]  pair_sum_ff, pair_sum_in;
   logic [7:0]  last_pair_ff, last_pair_in;
   logic [7:0]  count_field_ff, count_field_in;
   logic [15:0] address_field_ff, address_field_in;
   logic [7:0]  type_field_ff, type_field_in;
   logic        colon_seen_ff, colon_seen_in;

   // output and skid registers
   logic                 out_valid_ff, out_valid_in;
   ihex_pkg::rsp_type    out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   ihex_pkg::rsp_type    skid_ff, skid_in;

   // decode results
   logic              process;
   logic              res_valid;
   ihex_pkg::rsp_type res;
   logic              out_free;
   logic [7:0]        pair;
   logic [6:0]        pair_idx;
   logic [6:0]        data_idx;
   logic [9:0]        expect_len;
   logic [2:0]        st;

   // the input register advances unless a result has nowhere to go
   assign process   = in_valid_ff && !skid_valid_ff;
   assign req_stall = in_valid_ff && skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      in_kind_in  = req_stall ? in_kind_ff : req_kind;
      in_char_in  = req_stall ? in_char_ff : req_character;
   end

   // end-of-line status, checks in the file's order
   always_comb begin
      expect_len = {1'b0, count_field_ff, 1'b0} + {2'b00, ihex_pkg::MIN_LEN};
      if (!line_overflow_ff && char_position_ff < ihex_pkg::MIN_LEN) begin
         st = ihex_pkg::STATUS_SHORT;
      end else if (!colon_seen_ff) begin
         st = ihex_pkg::STATUS_NO_COLON;
      end else if (line_overflow_ff) begin
         st = ihex_pkg::STATUS_LENGTH;
      end else if (type_field_ff == ihex_pkg::TYPE_DATA &&
                   (expect_len != {2'b00, char_position_ff} || count_field_ff > MaxData)) begin
         st = ihex_pkg::STATUS_LENGTH;
      end else if (type_field_ff == ihex_pkg::TYPE_EOF && !char_position_ff[0]) begin
         st = ihex_pkg::STATUS_LENGTH;
      end else if (type_field_ff == ihex_pkg::TYPE_EOF && count_field_ff != 8'd0) begin
         st = ihex_pkg::STATUS_EOF_CNT;
      end else if (type_field_ff != ihex_pkg::TYPE_DATA && type_field_ff != ihex_pkg::TYPE_EOF) begin
         st = ihex_pkg::STATUS_TYPE;
      end else if ((~pair_sum_ff + 8'd1) != last_pair_ff) begin
         st = ihex_pkg::STATUS_CHECKSUM;
      end else begin
         st = ihex_pkg::STATUS_OK;
      end
   end

   // line decoder: state update and result for the registered item
   always_comb begin
      char_position_in = char_position_ff;
      line_overflow_in = line_overflow_ff;
      upper_digit_in   = upper_digit_ff;
      pair_sum_in      = pair_sum_ff;
      last_pair_in     = last_pair_ff;
      count_field_in   = count_field_ff;
      address_field_in = address_field_ff;
      type_field_in    = type_field_ff;
      colon_seen_in    = colon_seen_ff;
      res_valid        = 1'b0;
      pair             = ihex_pkg::pair_value(upper_digit_ff, in_char_ff);
      pair_idx         = char_position_ff[7:1] - 7'd1;
      data_idx         = pair_idx - 7'd4;
      res.result_kind  = ihex_pkg::RESULT_DATA;
      res.data_byte    = pair;
      res.byte_index   = data_idx[5:0];
      res.load_address = address_field_ff;
      res.byte_count   = count_field_ff;
      res.record_type  = type_field_ff;
      res.status       = ihex_pkg::STATUS_OK;
      if (process) begin
         if (in_kind_ff == ihex_pkg::KIND_EOL) begin
            res_valid       = 1'b1;
            res.result_kind = ihex_pkg::RESULT_STATUS;
            res.data_byte   = 8'd0;
            res.byte_index  = 6'd0;
            res.status      = st;
            if (st == ihex_pkg::STATUS_SHORT || st == ihex_pkg::STATUS_NO_COLON) begin
               res.load_address = 16'd0;
               res.byte_count   = 8'd0;
               res.record_type  = 8'd0;
            end
            char_position_in = 8'd0;
            line_overflow_in = 1'b0;
            upper_digit_in   = 8'd0;
            pair_sum_in      = 8'd0;
            last_pair_in     = 8'd0;
            count_field_in   = 8'd0;
            address_field_in = 16'd0;
            type_field_in    = 8'd0;
            colon_seen_in    = 1'b0;
         end else if (char_position_ff == ihex_pkg::POS_LIMIT) begin
            line_overflow_in = 1'b1;
         end else begin
            char_position_in = char_position_ff + 8'd1;
            if (char_position_ff == 8'd0) begin
               colon_seen_in = (in_char_ff == ihex_pkg::CHAR_COLON);
            end else if (char_position_ff[0]) begin
               upper_digit_in = in_char_ff;
            end else begin
               pair_sum_in  = pair_sum_ff + last_pair_ff;
               last_pair_in = pair;
               unique case (pair_idx)
                  7'd0: count_field_in = pair;
                  7'd1: address_field_in = {pair, address_field_ff[7:0]};
                  7'd2: address_field_in = {address_field_ff[15:8], pair};
                  7'd3: type_field_in = pair;
                  default: begin
                     res_valid = colon_seen_ff && type_field_ff == ihex_pkg::TYPE_DATA &&
                                 {1'b0, data_idx} < count_field_ff &&
                                 {1'b0, data_idx} < MaxData;
                  end
               endcase
            end
         end
      end
   end

   // output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
         char_position_ff <= 8'd0;
         line_overflow_ff <= 1'b0;
         upper_digit_ff   <= 8'd0;
         pair_sum_ff      <= 8'd0;
         last_pair_ff     <= 8'd0;
         count_field_ff   <= 8'd0;
         address_field_ff <= 16'd0;
         type_field_ff    <= 8'd0;
         colon_seen_ff    <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
         char_position_ff <= char_position_in;
         line_overflow_ff <= line_overflow_in;
         upper_digit_ff   <= upper_digit_in;
         pair_sum_ff      <= pair_sum_in;
         last_pair_ff     <= last_pair_in;
         count_field_ff   <= count_field_in;
         address_field_ff <= address_field_in;
         type_field_ff    <= type_field_in;
         colon_seen_ff    <= colon_seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_char_ff <= in_char_in;
      out_ff     <= out_in;
      skid_ff    <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_ff.result_kind;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_byte_index   = out_ff.byte_index;
   assign rsp_load_address = out_ff.load_address;
   assign rsp_byte_count   = out_ff.byte_count;
   assign rsp_record_type  = out_ff.record_type;
   assign rsp_status       = out_ff.status;

endmodule

FILE: rtl/ihex_checker.sv
`timescale 1ns / 1ps

module ihex_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [5:0]  rsp_byte_index,
   input logic [15:0] rsp_load_address,
   input logic [7:0]  rsp_byte_count,
   input logic [7:0]  rsp_record_type,
   input logic [2:0]  rsp_status
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte) &&
      $stable(rsp_status) && $stable(rsp_result_kind))
      else $error("stalled result transaction changed");

   // data bytes come only from data records and carry ok status
   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == ihex_pkg::RESULT_DATA |->
      rsp_status == ihex_pkg::STATUS_OK && rsp_record_type == ihex_pkg::TYPE_DATA &&
      {2'b00, rsp_byte_index} < rsp_byte_count)
      else $error("data transaction with inconsistent header fields");

   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ihex_pkg::STATUS_CHECKSUM)
      else $error("status code out of range");

   // short or colon-less lines report cleared header fields
   a_bad_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ihex_pkg::STATUS_SHORT ||
                    rsp_status == ihex_pkg::STATUS_NO_COLON) |->
      rsp_load_address == 16'd0 && rsp_byte_count == 8'd0 && rsp_record_type == 8'd0 &&
      rsp_data_byte == 8'd0)
      else $error("header fields not cleared on malformed line");

   // input backpressure only while the output side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid) && $past(rsp_stall) && !$past(req_valid && 1'b0))
      else $error("input stalled without output backpressure");

endmodule

bind intel_hex_record_parser_core ihex_checker u_ihex_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_load_address (rsp_load_address),
   .rsp_byte_count   (rsp_byte_count),
   .rsp_record_type  (rsp_record_type),
   .rsp_status       (rsp_status)
);

FILE: tb/sv/tb_intel_hex_record_parser_core.sv
`timescale 1ns / 1ps

module tb_intel_hex_record_parser_core;

   localparam int MAX_DATA       = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_ITEMS   = 870;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = ihex_pkg::KIND_CHAR;
   logic [7:0]  req_character = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [5:0]  rsp_byte_index;
   logic [15:0] rsp_load_address;
   logic [7:0]  rsp_byte_count;
   logic [7:0]  rsp_record_type;
   logic [2:0]  rsp_status;

   // decoded bytes and record statuses still to come out of the parser
   ihex_pkg::rsp_type expected_records[$];

   // line state of the predictor
   logic [7:0]  line_len = 8'h00;
   logic [7:0]  pending_hi = 8'h00;
   logic [7:0]  sum_of_pairs = 8'h00;
   logic [7:0]  newest_pair = 8'h00;
   logic [7:0]  count_fld = 8'h00;
   logic [15:0] addr_fld = 16'h0000;
   logic [7:0]  type_fld = 8'h00;
   logic        colon_fld = 1'b0;
   logic        overflow_fld = 1'b0;

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;
   bit  sender_gaps_on = 1'b0;
   bit  receiver_gaps_on = 1'b0;
   bit  hold_request = 1'b0;

   // characters of the line being built
   logic [7:0] line_buf[$];

   intel_hex_record_parser_core #(
      .MAX_DATA(MAX_DATA)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_character(req_character),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_load_address(rsp_load_address),
      .rsp_byte_count(rsp_byte_count),
      .rsp_record_type(rsp_record_type),
      .rsp_status(rsp_status)
   );

   // clock generation
   initial begin
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int random_gap();
      if ($urandom_range(0, 9) == 0) begin
         return int'($urandom_range(8, 40));
      end
      return int'($urandom_range(1, 3));
   endfunction

   // hex digit as the file format reads it, no validity check
   function automatic logic [7:0] nibble_of(input logic [7:0] c);
      if (c >= ihex_pkg::CHAR_UPPER_A && c < 8'h80) begin
         return c - ihex_pkg::CHAR_UPPER_A + 8'd10;
      end
      return c - ihex_pkg::CHAR_ZERO;
   endfunction

   // status of the finished line, checks in file order
   function automatic logic [2:0] record_verdict();
      int         len;
      int         need;
      logic [7:0] neg_sum;
      len = int'(line_len);
      need = 2 * int'(count_fld) + int'(ihex_pkg::MIN_LEN);
      neg_sum = (sum_of_pairs ^ ihex_pkg::POS_LIMIT) + 8'd1;
      if (!overflow_fld && len < int'(ihex_pkg::MIN_LEN)) begin
         return ihex_pkg::STATUS_SHORT;
      end
      if (!colon_fld) begin
         return ihex_pkg::STATUS_NO_COLON;
      end
      if (overflow_fld) begin
         return ihex_pkg::STATUS_LENGTH;
      end
      if (type_fld == ihex_pkg::TYPE_DATA) begin
         if (len != need || int'(count_fld) > MAX_DATA) begin
            return ihex_pkg::STATUS_LENGTH;
         end
      end else if (type_fld == ihex_pkg::TYPE_EOF) begin
         if (len[0] == 1'b0) begin
            return ihex_pkg::STATUS_LENGTH;
         end
         if (count_fld != 8'd0) begin
            return ihex_pkg::STATUS_EOF_CNT;
         end
      end else begin
         return ihex_pkg::STATUS_TYPE;
      end
      if (neg_sum != newest_pair) begin
         return ihex_pkg::STATUS_CHECKSUM;
      end
      return ihex_pkg::STATUS_OK;
   endfunction

   // advance the line state by one accepted transaction
   task automatic parse_item(input logic kind, input logic [7:0] ch);
      ihex_pkg::rsp_type r;
      int                pos;
      int                k;
      logic [7:0]        hv;
      logic [7:0]        lv;
      logic [7:0]        b;
      logic [2:0]        st;
      r = '0;
      if (kind == ihex_pkg::KIND_EOL) begin
         st = record_verdict();
         r.result_kind = ihex_pkg::RESULT_STATUS;
         r.status = st;
         if (st != ihex_pkg::STATUS_SHORT && st != ihex_pkg::STATUS_NO_COLON) begin
            r.load_address = addr_fld;
            r.byte_count = count_fld;
            r.record_type = type_fld;
         end
         expected_records.push_back(r);
         line_len = 8'h00;
         pending_hi = 8'h00;
         sum_of_pairs = 8'h00;
         newest_pair = 8'h00;
         count_fld = 8'h00;
         addr_fld = 16'h0000;
         type_fld = 8'h00;
         colon_fld = 1'b0;
         overflow_fld = 1'b0;
      end else if (line_len == ihex_pkg::POS_LIMIT) begin
         // characters past the limit only mark the line as too long
         overflow_fld = 1'b1;
      end else begin
         pos = int'(line_len);
         line_len = line_len + 8'd1;
         if (pos == 0) begin
            colon_fld = (ch == ihex_pkg::CHAR_COLON);
         end else if (pos % 2 == 1) begin
            pending_hi = ch;
         end else begin
            hv = nibble_of(pending_hi);
            lv = nibble_of(ch);
            b = {hv[3:0], 4'b0000} + lv;
            sum_of_pairs = sum_of_pairs + newest_pair;
            newest_pair = b;
            k = (pos - 2) / 2;
            case (k)
               0: count_fld = b;
               1: addr_fld[15:8] = b;
               2: addr_fld[7:0] = b;
               3: type_fld = b;
               default: begin
                  if (colon_fld && type_fld == ihex_pkg::TYPE_DATA &&
                      k - 4 < int'(count_fld) && k - 4 < MAX_DATA) begin
                     r.result_kind = ihex_pkg::RESULT_DATA;
                     r.data_byte = b;
                     r.byte_index = 6'(k - 4);
                     r.load_address = addr_fld;
                     r.byte_count = count_fld;
                     r.record_type = type_fld;
                     r.status = ihex_pkg::STATUS_OK;
                     expected_records.push_back(r);
                  end
               end
            endcase
         end
      end
   endtask

   // offer one transaction, optionally after a gap, and wait until it is taken
   task automatic send_item(input logic kind, input logic [7:0] ch);
      int gap;
      @(negedge clock);
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = random_gap();
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_character <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_item(kind, ch);
      items_sent++;
   endtask

   // send the buffered line followed by end of line
   task automatic send_line();
      logic [7:0] junk;
      foreach (line_buf[i]) begin
         send_item(ihex_pkg::KIND_CHAR, line_buf[i]);
      end
      junk = 8'($urandom);
      send_item(ihex_pkg::KIND_EOL, junk);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) begin
         return ihex_pkg::CHAR_ZERO + n;
      end
      return (lower ? "a" : ihex_pkg::CHAR_UPPER_A) + n - 8'd10;
   endfunction

   task automatic add_byte(input logic [7:0] b, input bit lower);
      line_buf.push_back(hex_char(b[7:4], lower));
      line_buf.push_back(hex_char(b[3:0], lower));
   endtask

   // build a record line with n_data data bytes, whatever the count field says
   task automatic build_record(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] rtype, input int n_data, input bit sum_ok);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] ck;
      bit         lower;
      lower = ($urandom_range(0, 19) == 0);
      line_buf.delete();
      line_buf.push_back(ihex_pkg::CHAR_COLON);
      sum = count + addr[15:8] + addr[7:0] + rtype;
      add_byte(count, lower);
      add_byte(addr[15:8], lower);
      add_byte(addr[7:0], lower);
      add_byte(rtype, lower);
      for (int i = 0; i < n_data; i++) begin
         b = 8'($urandom);
         sum = sum + b;
         add_byte(b, lower);
      end
      ck = ~sum + 8'd1;
      if (!sum_ok) begin
         ck = ck ^ 8'($urandom_range(1, 255));
      end
      add_byte(ck, lower);
   endtask

   // well-formed records at the field extremes
   task automatic test_directed_records();
      build_record(8'd3, 16'h0000, ihex_pkg::TYPE_DATA, 3, 1'b1);
      send_line();
      build_record(8'd1, 16'hFFFF, ihex_pkg::TYPE_DATA, 1, 1'b1);
      send_line();
      build_record(8'd0, 16'h1234, ihex_pkg::TYPE_DATA, 0, 1'b1);
      send_line();
      build_record(8'd0, 16'h0000, ihex_pkg::TYPE_EOF, 0, 1'b1);
      send_line();
      build_record(8'(MAX_DATA), 16'hA55A, ihex_pkg::TYPE_DATA, MAX_DATA, 1'b1);
      send_line();
   endtask

   // one line for each failing status and the odd characters
   task automatic test_status_cases();
      // empty line and a line one character short
      line_buf.delete();
      send_line();
      line_buf.delete();
      line_buf.push_back(ihex_pkg::CHAR_COLON);
      repeat (9) line_buf.push_back(ihex_pkg::CHAR_ZERO);
      send_line();
      // missing colon
      build_record(8'd2, 16'h0100, ihex_pkg::TYPE_DATA, 2, 1'b1);
      line_buf[0] = "X";
      send_line();
      // data length off by one and count above the maximum
      build_record(8'd5, 16'h0200, ihex_pkg::TYPE_DATA, 4, 1'b1);
      send_line();
      build_record(8'(MAX_DATA + 1), 16'h0300, ihex_pkg::TYPE_DATA, MAX_DATA + 1, 1'b1);
      send_line();
      // end record of even length, then with a nonzero count
      build_record(8'd0, 16'h0000, ihex_pkg::TYPE_EOF, 0, 1'b1);
      line_buf.push_back(ihex_pkg::CHAR_ZERO);
      send_line();
      build_record(8'd2, 16'h0000, ihex_pkg::TYPE_EOF, 2, 1'b1);
      send_line();
      // unknown type and bad checksum
      build_record(8'd1, 16'h0400, 8'h05, 1, 1'b1);
      send_line();
      build_record(8'd2, 16'h0500, ihex_pkg::TYPE_DATA, 2, 1'b0);
      send_line();
      // NUL and high-bit characters inside the data
      build_record(8'd3, 16'h0600, ihex_pkg::TYPE_DATA, 3, 1'b1);
      line_buf[9] = 8'h00;
      line_buf[10] = 8'hFF;
      line_buf[11] = 8'h80;
      line_buf[12] = 8'h7F;
      send_line();
      // exactly 255 characters, then a line past the limit
      build_record(8'd122, 16'h0700, ihex_pkg::TYPE_DATA, 122, 1'b1);
      send_line();
      build_record(8'd130, 16'h0800, ihex_pkg::TYPE_DATA, 130, 1'b1);
      send_line();
   endtask

   // receiver holds off long enough that the parser fills up and stalls
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (3) begin
         build_record(8'd8, 16'($urandom), ihex_pkg::TYPE_DATA, 8, 1'b1);
         send_line();
      end
   endtask

   // mostly well-formed records with random content, some noise and damage
   task automatic test_random_lines();
      int         target;
      int         pick;
      int         n_data;
      int         len;
      int         at;
      logic [7:0] count;
      logic [7:0] rtype;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         sender_gaps_on = (pick != 0 && pick != 1);
         receiver_gaps_on = (pick != 0 && pick != 2);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            line_buf.delete();
            len = $urandom_range(0, 30);
            for (int i = 0; i < len; i++) begin
               line_buf.push_back(8'($urandom));
            end
            if (len > 0 && $urandom_range(0, 1) == 0) begin
               line_buf[0] = ihex_pkg::CHAR_COLON;
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               rtype = ihex_pkg::TYPE_DATA;
               count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, MAX_DATA + 4))
                                                   : 8'($urandom_range(0, 16));
            end else if (pick < 85) begin
               rtype = ihex_pkg::TYPE_EOF;
               count = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
            end else begin
               rtype = 8'($urandom);
               count = 8'($urandom_range(0, 8));
            end
            n_data = int'(count);
            if ($urandom_range(0, 19) == 0) begin
               n_data = (count == 0) ? 1 : int'(count) + int'($urandom_range(0, 1)) * 2 - 1;
            end
            build_record(count, 16'($urandom), rtype, n_data, $urandom_range(0, 9) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               at = $urandom_range(0, line_buf.size() - 1);
               line_buf[at] = 8'($urandom);
            end else if (pick < 8) begin
               void'(line_buf.pop_back());
            end
         end
         send_line();
      end
      sender_gaps_on = 1'b1;
      receiver_gaps_on = 1'b1;
   endtask

   // receiver stall pattern, with the long hold-off counted here
   initial begin : receiver_stalls
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (receiver_gaps_on && $urandom_range(0, 3) == 0) begin
               stall_left = random_gap();
            end
         end
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin : check_results
      ihex_pkg::rsp_type seen;
      ihex_pkg::rsp_type want;
      if (rsp_valid && !rsp_stall) begin
         seen = {rsp_result_kind, rsp_data_byte, rsp_byte_index, rsp_load_address,
                 rsp_byte_count, rsp_record_type, rsp_status};
         if (expected_records.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result: kind %0d byte %h idx %0d addr %h cnt %h type %h st %0d",
                        seen.result_kind, seen.data_byte, seen.byte_index, seen.load_address,
                        seen.byte_count, seen.record_type, seen.status);
            end
         end else begin
            want = expected_records.pop_front();
            if (seen.result_kind !== want.result_kind || seen.data_byte !== want.data_byte ||
                seen.byte_index !== want.byte_index ||
                seen.load_address !== want.load_address ||
                seen.byte_count !== want.byte_count || seen.record_type !== want.record_type ||
                seen.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch expected: kind %0d byte %h idx %0d addr %h cnt %h type %h st %0d",
                           want.result_kind, want.data_byte, want.byte_index, want.load_address,
                           want.byte_count, want.record_type, want.status);
                  $display("         actual:   kind %0d byte %h idx %0d addr %h cnt %h type %h st %0d",
                           seen.result_kind, seen.data_byte, seen.byte_index, seen.load_address,
                           seen.byte_count, seen.record_type, seen.status);
               end
            end
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      sender_gaps_on = 1'b1;
      receiver_gaps_on = 1'b1;
      test_directed_records();
      test_status_cases();
      test_backpressure();
      test_random_lines();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
